// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define CHK_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled while dis is high.
`define CHK_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== sv/bhd_pkg.sv =====
// Constants, types and the exp2 fraction table of the Hawkes decay block.
// No dependencies.
package bhd_pkg;

    localparam int EVT_W           = 32;
    localparam int TIME_BITS       = 32;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
    localparam int IDXP_W          = 24 + IDX_W + 1;
    localparam int BETA_W          = 32;
    localparam int SUM_W           = 40;
    localparam int FAC_W           = 33;
    localparam int TIE_W           = 16;
    localparam int MUL_W           = 34;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO = 2'd1;

    localparam logic [BETA_W-1:0] BETA_RESET = 32'd16777216;
    localparam logic [FAC_W-1:0]  FAC_ONE    = 33'h1_0000_0000;
    localparam logic [32:0]       LOG2E_Q32  = 33'd6196328018;
    localparam logic [63:0]       LN2_Q31    = 64'd1488522236;
    localparam logic [63:0]       X_LIMIT    = 64'd48 << 24;
    localparam logic [SUM_W-1:0]  ONE_Q16    = 40'd65536;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [TIE_W-1:0]  TIE_MAX    = {TIE_W{1'b1}};

    typedef logic [EXP_TABLE_DEPTH-1:0][FAC_W-1:0] t_exp_tab;

    // 2^(-k/D) in Q1.32 by a truncating alternating series in ln2
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] z;
        logic [63:0] acc;
        logic [63:0] term;
        bit          done;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            z    = (64'(k) * LN2_Q31) / EXP_TABLE_DEPTH;
            acc  = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            done = 1'b0;
            for (int n = 1; n <= 24; n++) begin
                if (!done) begin
                    term = ((term * z) >> 31) / 64'(n);
                    if (term == 64'd0) begin
                        done = 1'b1;
                    end else if (n % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
            tab[k] = acc[FAC_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== sv/bivariate_hawkes_decay_recursion.sv =====
// Bivariate Hawkes exponential-kernel recursion, one shared multiplier.
// Depends on bhd_pkg.
//
//  channel | valid       | flow control | payload
//  --------+-------------+--------------+------------------------------------------
//  event   | i_valid     | o_stall      | i_event_time, i_stream_tag, i_last_event
//  result  | o_valid     | i_stall      | o_out_tag, o_self_term, o_cross_term,
//          |             |              | o_order_error
//  config  | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An event whose time does not advance goes from accept through check to update.
// An advancing event also runs, per kernel, one multiply for beta*dt, one for the
// log2 scaling, a table lookup, then two partial products for each of two sums,
// all on the one 34x34 multiplier. A stalled result blocks only the final step.
// Synchronous active-low reset clears all sums and control; no clearing pass.
module bivariate_hawkes_decay_recursion (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bhd_pkg::EVT_W-1:0]       i_event_time,
    input  logic                            i_stream_tag,
    input  logic                            i_last_event,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_out_tag,
    output logic [bhd_pkg::SUM_W-1:0]       o_self_term,
    output logic [bhd_pkg::SUM_W-1:0]       o_cross_term,
    output logic                            o_order_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bhd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhd_pkg::BETA_W-1:0]      i_cfg_data
);
    import bhd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MX    = 4'd2;
    localparam logic [3:0] S_ML    = 4'd3;
    localparam logic [3:0] S_FX    = 4'd4;
    localparam logic [3:0] S_SM0   = 4'd5;
    localparam logic [3:0] S_SM1   = 4'd6;
    localparam logic [3:0] S_SM2   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0]           r_state;
    logic [BETA_W-1:0]    r_beta1, r_beta2;
    logic [TIME_BITS-1:0] r_ref;
    logic [SUM_W-1:0]     r_s11, r_c12, r_c21, r_s22;
    logic [1:0]           r_seen;
    logic [TIE_W-1:0]     r_tie0, r_tie1;
    logic                 r_err, r_kern, r_half, r_big;
    logic                 r_ovalid;

    logic [TIME_BITS-1:0] r_t, r_dt;
    logic                 r_s, r_last;
    logic [FAC_W-1:0]     r_fac;
    logic [PROD_W-1:0]    r_prod;
    logic [52:0]          r_acc;
    logic                 r_otag, r_oerr;
    logic [SUM_W-1:0]     r_oself, r_ocross;

    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    n_prod;
    logic [SUM_W-1:0]     sum_sel;
    logic [BETA_W-1:0]    beta_sel;
    logic [30:0]          y;
    logic [6:0]           exp_n;
    logic [IDXP_W-1:0]    idx_prod;
    logic [IDX_W-1:0]     idx;
    logic [FAC_W-1:0]     n_fac;
    logic [73:0]          sc_full;
    logic [SUM_W-1:0]     scaled;
    logic                 out_free;

    assign o_stall       = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_out_tag     = r_otag;
    assign o_self_term   = r_oself;
    assign o_cross_term  = r_ocross;
    assign o_order_error = r_oerr;
    assign out_free      = !r_ovalid || !i_stall;

    assign beta_sel = r_kern ? r_beta2 : r_beta1;

    always_comb begin
        unique case ({r_kern, r_half})
            2'b00:   sum_sel = r_s11;
            2'b01:   sum_sel = r_c12;
            2'b10:   sum_sel = r_c21;
            default: sum_sel = r_s22;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MX: begin
                mul_a = MUL_W'(beta_sel);
                mul_b = MUL_W'(r_dt);
            end
            S_ML: begin
                mul_a = MUL_W'(r_prod[29:0]);
                mul_b = MUL_W'(LOG2E_Q32);
            end
            S_SM0: begin
                mul_a = MUL_W'(sum_sel[19:0]);
                mul_b = MUL_W'(r_fac);
            end
            S_SM1: begin
                mul_a = MUL_W'(sum_sel[39:20]);
                mul_b = MUL_W'(r_fac);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    // decay factor from y = floor(x*log2e) in Q.24
    always_comb begin
        y        = r_prod[62:32];
        exp_n    = y[30:24];
        idx_prod = IDXP_W'(y[23:0]) * IDXP_W'(EXP_TABLE_DEPTH);
        idx      = idx_prod[24 +: IDX_W];
        if (beta_sel == '0) begin
            n_fac = FAC_ONE;
        end else if (r_big || exp_n >= 7'd33) begin
            n_fac = '0;
        end else begin
            n_fac = EXP_TAB[idx] >> exp_n;
        end
    end

    // sum * f >> 32 from the low (r_acc) and high (r_prod) partial products
    assign sc_full = 74'(r_acc) + (74'(r_prod[52:0]) << 20);
    assign scaled  = sc_full[71:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_beta1  <= BETA_RESET;
            r_beta2  <= BETA_RESET;
            r_ref    <= '0;
            r_s11    <= '0;
            r_c12    <= '0;
            r_c21    <= '0;
            r_s22    <= '0;
            r_seen   <= '0;
            r_tie0   <= '0;
            r_tie1   <= '0;
            r_err    <= 1'b0;
            r_kern   <= 1'b0;
            r_half   <= 1'b0;
            r_big    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_BETA_ONE) begin
                    r_beta1 <= i_cfg_data;
                end else if (i_cfg_index == REG_BETA_TWO) begin
                    r_beta2 <= i_cfg_data;
                end
            end
            if (r_state == S_UPD && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_err  <= (r_seen != 2'b00 && r_t < r_ref);
                    r_kern <= 1'b0;
                    r_half <= 1'b0;
                    priority if (r_seen != 2'b00 && r_t < r_ref) begin
                        r_state <= S_UPD;
                    end else if (r_seen == 2'b00) begin
                        r_ref   <= r_t;
                        r_state <= S_UPD;
                    end else if (r_t > r_ref) begin
                        // fold equal-time events of the other stream in at weight one
                        if (r_seen[0]) begin
                            r_c12 <= sat_add(r_c12, SUM_W'(r_tie1) << 16);
                        end
                        if (r_seen[1]) begin
                            r_c21 <= sat_add(r_c21, SUM_W'(r_tie0) << 16);
                        end
                        r_tie0  <= '0;
                        r_tie1  <= '0;
                        r_ref   <= r_t;
                        r_state <= S_MX;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_MX: begin
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_big   <= (r_prod[63:0] >= X_LIMIT);
                    r_state <= S_FX;
                end
                S_FX: begin
                    r_half  <= 1'b0;
                    r_state <= S_SM0;
                end
                S_SM0: begin
                    r_state <= S_SM1;
                end
                S_SM1: begin
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    unique case ({r_kern, r_half})
                        2'b00:   r_s11 <= scaled;
                        2'b01:   r_c12 <= scaled;
                        2'b10:   r_c21 <= scaled;
                        default: r_s22 <= scaled;
                    endcase
                    if (!r_half) begin
                        r_half  <= 1'b1;
                        r_state <= S_SM0;
                    end else if (!r_kern) begin
                        r_kern  <= 1'b1;
                        r_state <= S_MX;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_last) begin
                            r_ref  <= '0;
                            r_s11  <= '0;
                            r_c12  <= '0;
                            r_c21  <= '0;
                            r_s22  <= '0;
                            r_seen <= '0;
                            r_tie0 <= '0;
                            r_tie1 <= '0;
                        end else if (!r_err) begin
                            if (!r_s) begin
                                r_s11   <= sat_add(r_s11, ONE_Q16);
                                r_seen[0] <= 1'b1;
                                if (r_tie0 != TIE_MAX) begin
                                    r_tie0 <= r_tie0 + 1'b1;
                                end
                            end else begin
                                r_s22   <= sat_add(r_s22, ONE_Q16);
                                r_seen[1] <= 1'b1;
                                if (r_tie1 != TIE_MAX) begin
                                    r_tie1 <= r_tie1 + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath and output payload
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_state == S_IDLE && i_valid) begin
            r_t    <= i_event_time[TIME_BITS-1:0];
            r_s    <= i_stream_tag;
            r_last <= i_last_event;
        end
        if (r_state == S_CHECK) begin
            r_dt <= r_t - r_ref;
        end
        if (r_state == S_FX) begin
            r_fac <= n_fac;
        end
        if (r_state == S_SM1) begin
            r_acc <= r_prod[52:0];
        end
        if (r_state == S_UPD && out_free) begin
            r_otag <= r_s;
            r_oerr <= r_err;
            if (r_err) begin
                r_oself  <= '0;
                r_ocross <= '0;
            end else if (!r_s) begin
                r_oself  <= r_s11;
                r_ocross <= r_c12;
            end else begin
                r_oself  <= r_s22;
                r_ocross <= r_c21;
            end
        end
    end

endmodule

// ===== sv/bhd_checker.sv =====
// Port-level checks for the Hawkes decay block, bound to the top level.
// Depends on bhd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bhd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic [bhd_pkg::EVT_W-1:0]       i_event_time,
    input  logic                            i_stream_tag,
    input  logic                            i_last_event,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic                            o_out_tag,
    input  logic [bhd_pkg::SUM_W-1:0]       o_self_term,
    input  logic [bhd_pkg::SUM_W-1:0]       o_cross_term,
    input  logic                            o_order_error,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [bhd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhd_pkg::BETA_W-1:0]      i_cfg_data
);
    import bhd_pkg::*;

    // a dropped event reports no terms
    `CHK_IMP(a_err_zero, i_clk, !i_rst_n, o_valid && o_order_error, o_self_term == '0 && o_cross_term == '0)
    // one transaction at a time: busy right after an accept
    `CHK_NXT(a_busy_after_accept, i_clk, !i_rst_n, i_valid && !o_stall, o_stall)
    // a waiting result holds
    `CHK_NXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_self_term) && $stable(o_cross_term))
    // reset empties the output
    `CHK_NXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_valid && !o_stall)

endmodule

bind bivariate_hawkes_decay_recursion bhd_checker u_bhd_checker (.*);

// ===== bench/bivariate_hawkes_decay_recursion_test.sv =====
// Self-checking bench for bivariate_hawkes_decay_recursion: directed events, then
// random event sequences under several decay rates, with a built-in kernel predictor.
// Depends on bhd_pkg and the block.
`timescale 1ns / 1ps

module bivariate_hawkes_decay_recursion_test;
    import bhd_pkg::*;

    typedef struct packed {
        logic             tag;
        logic [SUM_W-1:0] self_v;
        logic [SUM_W-1:0] cross_v;
        logic             err;
    } t_kernel_out;

    typedef struct {
        logic [31:0] t;
        logic        tag;
        logic        last;
        bit          typed;
        t_kernel_out want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [EVT_W-1:0]     i_event_time;
    logic                 i_stream_tag;
    logic                 i_last_event;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_out_tag;
    logic [SUM_W-1:0]     o_self_term;
    logic [SUM_W-1:0]     o_cross_term;
    logic                 o_order_error;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BETA_W-1:0]    i_cfg_data;

    bivariate_hawkes_decay_recursion DUT (.*);

    always #6 i_clk = ~i_clk;

    // kernel predictor state
    longint unsigned frac_tab [EXP_TABLE_DEPTH];
    longint unsigned rate_one, rate_two;
    longint unsigned last_time, r11, r12, r21, r22;
    logic [1:0]      seen;
    longint unsigned ties [2];

    t_kernel_out pending_results [$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt = 0;
    int          stall_burst = 0;
    int          idle_cycles = 0;

    function automatic void build_frac_tab();
        longint unsigned z, acc, term;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            z = (longint'(k) * 64'd1488522236) / EXP_TABLE_DEPTH;
            acc = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            for (int n = 1; n <= 24; n++) begin
                term = ((term * z) >> 31) / n;
                if (term == 0) break;
                if (n % 2 == 1) acc -= term;
                else acc += term;
            end
            frac_tab[k] = acc;
        end
    endfunction

    function automatic longint unsigned decay_mult(longint unsigned rate, longint unsigned dt);
        longint unsigned x, y, n, idx;
        if (rate == 0) return 64'h1_0000_0000;
        x = rate * dt;
        if (x >= (64'd48 << 24)) return 0;
        y = (x * 64'd6196328018) >> 32;
        n = y >> 24;
        idx = ((y & 64'hFF_FFFF) * EXP_TABLE_DEPTH) >> 24;
        if (n >= 33) return 0;
        return frac_tab[idx] >> n;
    endfunction

    // sum * factor, Q24.16 times Q1.32, truncated
    function automatic longint unsigned shrink(longint unsigned s, longint unsigned f);
        longint unsigned p, q;
        p = (s >> 20) * f;
        q = (s & 64'hF_FFFF) * f;
        return (p >> 12) + ((((p & 64'hFFF) << 20) + q) >> 32);
    endfunction

    function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    function automatic void clear_kernels();
        last_time = 0; r11 = 0; r12 = 0; r21 = 0; r22 = 0;
        seen = 2'b00; ties[0] = 0; ties[1] = 0;
    endfunction

    function automatic t_kernel_out kernel_event(logic [31:0] t, logic tag, logic last);
        t_kernel_out r;
        longint unsigned f1, f2;
        r = '0;
        r.tag = tag;
        if (seen != 0 && t < last_time) begin
            r.err = 1'b1;
        end else begin
            if (seen == 0) begin
                last_time = t;
            end else if (t > last_time) begin
                f1 = decay_mult(rate_one, t - last_time);
                f2 = decay_mult(rate_two, t - last_time);
                // equal-time events of the other stream fold in when time moves
                if (seen[0]) r12 = sum_sat(r12, ties[1] * ONE_Q16);
                if (seen[1]) r21 = sum_sat(r21, ties[0] * ONE_Q16);
                ties[0] = 0; ties[1] = 0;
                r11 = shrink(r11, f1); r12 = shrink(r12, f1);
                r21 = shrink(r21, f2); r22 = shrink(r22, f2);
                last_time = t;
            end
            if (!tag) begin
                r.self_v = r11; r.cross_v = r12; r11 = sum_sat(r11, ONE_Q16);
            end else begin
                r.self_v = r22; r.cross_v = r21; r22 = sum_sat(r22, ONE_Q16);
            end
            seen[tag] = 1'b1;
            if (ties[tag] < 16'hFFFF) ties[tag]++;
        end
        if (last) clear_kernels();
        return r;
    endfunction

    // result side: stall bursts, long hold, checking, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 300;
            i_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_burst <= $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_kernel_out w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction tag=%0d self=%h cross=%h err=%0d",
                         $time, o_out_tag, o_self_term, o_cross_term, o_order_error);
                failed = 1'b1;
            end else begin
                w = pending_results.pop_front();
                if (o_out_tag !== w.tag) begin
                    $display("%0t: out_tag expected %0d actual %0d", $time, w.tag, o_out_tag);
                    failed = 1'b1;
                end
                if (o_self_term !== w.self_v) begin
                    $display("%0t: self_term expected %h actual %h", $time, w.self_v,
                             o_self_term);
                    failed = 1'b1;
                end
                if (o_cross_term !== w.cross_v) begin
                    $display("%0t: cross_term expected %h actual %h", $time, w.cross_v,
                             o_cross_term);
                    failed = 1'b1;
                end
                if (o_order_error !== w.err) begin
                    $display("%0t: order_error expected %0d actual %0d", $time, w.err,
                             o_order_error);
                    failed = 1'b1;
                end
            end
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("bivariate_hawkes_decay_recursion_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(logic [31:0] t, logic tag, logic last, bit typed,
                              t_kernel_out want);
        t_kernel_out p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_event_time <= t;
        i_stream_tag <= tag;
        i_last_event <= last;
        do @(posedge i_clk); while (o_stall);
        p = kernel_event(t, tag, last);
        pending_results.push_back(typed ? want : p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_BETA_ONE) rate_one = val;
        else rate_two = val;
    endtask

    task automatic random_sequence(int len);
        logic [31:0] t, tb;
        longint unsigned nt;
        int r;
        t = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (k > 0 && r < 5 && t > 0) begin
                tb = $urandom_range(0, t - 1);
                send_event(tb, $urandom_range(0, 1), k == len - 1, 1'b0, '0);
            end else begin
                if (k > 0) begin
                    if (r < 35) nt = t;
                    else if (r < 80) nt = t + $urandom_range(1, 8);
                    else if (r < 95) nt = t + $urandom_range(1, 1000);
                    else nt = t + $urandom;
                    t = (nt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nt[31:0];
                end
                send_event(t, $urandom_range(0, 1),
                           (k == len - 1) || ($urandom_range(0, 49) == 0), 1'b0, '0);
            end
        end
    endtask

    t_row dir [15];
    int   sent;
    int   seq_len;

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_event_time <= '0;
        i_stream_tag <= 1'b0;
        i_last_event <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_BETA_ONE;
        i_cfg_data <= '0;
        build_frac_tab();
        rate_one = BETA_RESET;
        rate_two = BETA_RESET;
        clear_kernels();

        // first events and backward time give values known without the predictor
        dir[0]  = '{32'd100, 1'b0, 1'b0, 1'b1, '{1'b0, 40'd0, 40'd0, 1'b0}};
        dir[1]  = '{32'd100, 1'b1, 1'b0, 1'b1, '{1'b1, 40'd0, 40'd0, 1'b0}};
        dir[2]  = '{32'd100, 1'b0, 1'b0, 1'b1, '{1'b0, 40'd65536, 40'd0, 1'b0}};
        dir[3]  = '{32'd50,  1'b1, 1'b0, 1'b1, '{1'b1, 40'd0, 40'd0, 1'b1}};
        dir[4]  = '{32'd101, 1'b0, 1'b0, 1'b0, '0};
        dir[5]  = '{32'd101, 1'b1, 1'b0, 1'b0, '0};
        dir[6]  = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0};
        dir[7]  = '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0};
        dir[8]  = '{32'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 40'd0, 40'd0, 1'b0}};
        dir[9]  = '{32'd0, 1'b0, 1'b0, 1'b0, '0};
        dir[10] = '{32'd5, 1'b0, 1'b0, 1'b0, '0};
        dir[11] = '{32'd5, 1'b1, 1'b0, 1'b0, '0};
        dir[12] = '{32'd3, 1'b0, 1'b1, 1'b1, '{1'b0, 40'd0, 40'd0, 1'b1}};
        dir[13] = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '{1'b0, 40'd0, 40'd0, 1'b0}};
        dir[14] = '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, '{1'b1, 40'd0, 40'd0, 1'b0}};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir[i])
            send_event(dir[i].t, dir[i].tag, dir[i].last, dir[i].typed, dir[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin write_rate(REG_BETA_ONE, 32'd0); write_rate(REG_BETA_TWO, '1); end
                1: begin write_rate(REG_BETA_ONE, '1); write_rate(REG_BETA_TWO, 32'd0); end
                2: begin
                    write_rate(REG_BETA_ONE, $urandom_range(1 << 18, 1 << 25));
                    write_rate(REG_BETA_TWO, $urandom_range(1 << 18, 1 << 25));
                end
                3: begin write_rate(REG_BETA_ONE, $urandom); write_rate(REG_BETA_TWO, $urandom); end
                4: begin
                    write_rate(REG_BETA_ONE, $urandom_range(1, 1 << 16));
                    write_rate(REG_BETA_TWO, $urandom_range(1 << 20, 1 << 24));
                end
                default: begin
                    write_rate(REG_BETA_ONE, BETA_RESET);
                    write_rate(REG_BETA_TWO, BETA_RESET);
                    quiet = 1'b1;
                end
            endcase
            if (ph == 2) hold_req = 1'b1;
            sent = 0;
            while (sent < 165) begin
                seq_len = $urandom_range(1, 30);
                random_sequence(seq_len);
                sent = sent + seq_len;
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (!failed) begin
            $display("bivariate_hawkes_decay_recursion_test passed");
        end else begin
            $display("bivariate_hawkes_decay_recursion_test failed");
        end
        $finish;
    end

endmodule
